// File: hw/rtl/scva_pkg.sv
// Package for the capsule vertex attribute unit: payload structs, constants,
// CORDIC angle table. No dependencies.
package scva_pkg;

  localparam int unsigned NumRegs = 7;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SqrtStages = 8;
  localparam int unsigned LaneLatency = 1 + CordicSteps + SqrtStages;
  localparam logic [15:0] RadiusReset = 16'd256;

  localparam logic [2:0] RegRadius = 3'd0;
  localparam logic [2:0] RegTopX   = 3'd1;
  localparam logic [2:0] RegTopY   = 3'd2;
  localparam logic [2:0] RegTopZ   = 3'd3;
  localparam logic [2:0] RegBotX   = 3'd4;
  localparam logic [2:0] RegBotY   = 3'd5;
  localparam logic [2:0] RegBotZ   = 3'd6;

  localparam logic signed [15:0] SeamLo = 16'sd615;
  localparam logic signed [15:0] SeamHi = 16'sd3481;
  localparam logic signed [15:0] OneU   = 16'sd4096;

  localparam logic [20:0] QuarterTurn = 21'd262144;
  localparam logic [20:0] HalfTurn    = 21'd524288;
  localparam logic [20:0] FullTurn    = 21'd1048576;

  typedef struct packed {
    logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  } tri_t;

  typedef struct packed {
    logic signed [15:0] pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v;
    logic               last;
  } vtx_t;

  // Per-lane result with the data the merge stage needs.
  typedef struct packed {
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } lane_uv_t;

  function automatic logic [17:0] atan_entry(input logic [3:0] i);
    unique case (i)
      4'd0: atan_entry = 18'd131072;  4'd1: atan_entry = 18'd77376;
      4'd2: atan_entry = 18'd40884;   4'd3: atan_entry = 18'd20753;
      4'd4: atan_entry = 18'd10417;   4'd5: atan_entry = 18'd5213;
      4'd6: atan_entry = 18'd2607;    4'd7: atan_entry = 18'd1304;
      4'd8: atan_entry = 18'd652;     4'd9: atan_entry = 18'd326;
      4'd10: atan_entry = 18'd163;    4'd11: atan_entry = 18'd81;
      4'd12: atan_entry = 18'd41;     4'd13: atan_entry = 18'd20;
      4'd14: atan_entry = 18'd10;     default: atan_entry = 18'd5;
    endcase
  endfunction

endpackage

// File: hw/rtl/scva_cordic.sv
// Pipelined 16-stage vectoring CORDIC giving the first-quadrant angle of
// (ax, ay) in 2^-20 turn. Depends on scva_pkg. Carries a tag alongside.
module scva_cordic import scva_pkg::*; #(
  parameter int unsigned TagW = 8
) (
  input  logic            clk,
  input  logic [15:0]     ax,
  input  logic [15:0]     ay,
  input  logic [TagW-1:0] tag_in,
  output logic [18:0]     angle,
  output logic [TagW-1:0] tag_out
);

  // X grows to about 1.65 * sqrt(2) * 2^30; Y stays within +-2^31.
  logic signed [33:0] xs [CordicSteps+1];
  logic signed [33:0] ys [CordicSteps+1];
  logic signed [19:0] acc [CordicSteps+1];
  logic [1:0]         spc [CordicSteps+1];  // bit0: ay zero, bit1: ax zero
  logic [TagW-1:0]    tags [CordicSteps+1];

  always_comb begin
    xs[0]   = {4'd0, ax, 14'd0};
    ys[0]   = {4'd0, ay, 14'd0};
    acc[0]  = '0;
    spc[0]  = {ax == 16'd0, ay == 16'd0};
    tags[0] = tag_in;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!ys[i][33]) begin
        xs[i+1]  <= xs[i] + (ys[i] >>> i);
        ys[i+1]  <= ys[i] - (xs[i] >>> i);
        acc[i+1] <= acc[i] + 20'(atan_entry(4'(i)));
      end else begin
        xs[i+1]  <= xs[i] - (ys[i] >>> i);
        ys[i+1]  <= ys[i] + (xs[i] >>> i);
        acc[i+1] <= acc[i] - 20'(atan_entry(4'(i)));
      end
      spc[i+1]  <= spc[i];
      tags[i+1] <= tags[i];
    end
  end

  always_comb begin
    priority if (spc[CordicSteps][0]) angle = '0;
    else if (spc[CordicSteps][1]) angle = QuarterTurn[18:0];
    else if (acc[CordicSteps][19]) angle = '0;
    else if (acc[CordicSteps] > 20'sd262144) angle = QuarterTurn[18:0];
    else angle = acc[CordicSteps][18:0];
    tag_out = tags[CordicSteps];
  end

endmodule

// File: hw/rtl/scva_lane.sv
// One corner lane: u and v of a single vertex from its position, fully pipelined.
// Depends on scva_pkg and scva_cordic.
module scva_lane import scva_pkg::*; (
  input  logic               clk,
  input  logic               go,
  input  logic signed [15:0] px, py, pz,
  output lane_uv_t           uv,
  output logic               done
);

  localparam int unsigned SqW = SqrtStages;  // sqrt pipeline stages (two bits each, one in the last)

  // Front: absolute values, z clamp, start of sqrt.
  logic [15:0] ux, uy;
  logic [14:0] azc;
  logic        zneg;
  always_comb begin
    ux = px[15] ? 16'(-px) : px;
    uy = py[15] ? 16'(-py) : py;
    zneg = pz[15];
    if (pz > 16'sd16384) azc = 15'd16384;
    else if (pz < -16'sd16384) azc = 15'd16384;
    else azc = pz[15] ? 15'(-pz) : 15'(pz);
  end

  // u path: register the sign / pole flags, then the CORDIC.
  logic [15:0] ux_r, uy_r;
  logic [2:0]  uflag_r;  // x<0, y<0, pole
  logic [14:0] az_r;
  logic        zneg_r;
  logic [28:0] rad_r;
  always_ff @(posedge clk) begin
    ux_r    <= ux;
    uy_r    <= uy;
    uflag_r <= {px[15], py[15], (ux == 16'd0) && (uy == 16'd0)};
    az_r    <= azc;
    zneg_r  <= zneg;
    rad_r   <= 29'd268435456 - ({14'd0, azc} * {14'd0, azc});
  end

  logic [18:0] ua;
  logic [2:0]  uflag_o;
  scva_cordic #(.TagW(3)) u_cordic_u (
    .clk(clk), .ax(ux_r), .ay(uy_r), .tag_in(uflag_r),
    .angle(ua), .tag_out(uflag_o)
  );

  // v path: restoring sqrt, two result bits per stage (one in the last), then CORDIC.
  logic [28:0] sn  [SqW+1];
  logic [14:0] sr  [SqW+1];
  logic [14:0] sz  [SqW+1];
  logic        sneg[SqW+1];
  always_comb begin
    sn[0] = rad_r; sr[0] = '0; sz[0] = az_r; sneg[0] = zneg_r;
  end
  for (genvar s = 0; s < SqW; s++) begin : g_sq
    // This stage settles result bit BitHi and, where BitHi > 0, bit BitHi - 1.
    localparam int BitHi = 14 - 2 * s;
    logic [28:0] n_a, n_b;
    logic [14:0] r_a, r_b;
    logic [29:0] trial_a;
    always_comb begin
      trial_a = (({15'd0, sr[s]} << 1) | (30'd1 << BitHi)) << BitHi;
      n_a = sn[s];
      r_a = sr[s];
      if ({1'b0, sn[s]} >= trial_a) begin
        n_a = 29'({1'b0, sn[s]} - trial_a);
        r_a[BitHi] = 1'b1;
      end
    end
    if (BitHi > 0) begin : g_lo
      logic [29:0] trial_b;
      always_comb begin
        trial_b = (({15'd0, r_a} << 1) | (30'd1 << (BitHi - 1))) << (BitHi - 1);
        n_b = n_a;
        r_b = r_a;
        if ({1'b0, n_a} >= trial_b) begin
          n_b = 29'({1'b0, n_a} - trial_b);
          r_b[BitHi - 1] = 1'b1;
        end
      end
    end else begin : g_no_lo
      assign n_b = n_a;
      assign r_b = r_a;
    end
    always_ff @(posedge clk) begin
      sn[s+1] <= n_b; sr[s+1] <= r_b; sz[s+1] <= sz[s]; sneg[s+1] <= sneg[s];
    end
  end

  logic [18:0] va;
  logic        vneg_o;
  scva_cordic #(.TagW(1)) u_cordic_v (
    .clk(clk), .ax({1'b0, sr[SqW]}), .ay({1'b0, sz[SqW]}), .tag_in(sneg[SqW]),
    .angle(va), .tag_out(vneg_o)
  );

  // u unfold; delay it through SqW registers to line up with v, which also passes the SqW sqrt stages.
  logic [20:0] ang;
  logic [15:0] u_now;
  always_comb begin
    unique case ({uflag_o[2], uflag_o[1]})
      2'b00: ang = 21'(ua);
      2'b10: ang = HalfTurn - 21'(ua);
      2'b11: ang = HalfTurn + 21'(ua);
      default: ang = (FullTurn - 21'(ua)) & 21'hFFFFF;
    endcase
    u_now = uflag_o[0] ? 16'd1024 : 16'((ang + 21'd128) >> 8);
  end

  logic [15:0] u_dly [SqW+1];
  always_comb u_dly[0] = u_now;
  for (genvar d = 0; d < SqW; d++) begin : g_ud
    always_ff @(posedge clk) u_dly[d+1] <= u_dly[d];
  end

  logic [19:0] tv;
  always_comb begin
    tv = vneg_o ? 20'(QuarterTurn) - 20'(va) : 20'(QuarterTurn) + 20'(va);
    uv.tex_u = u_dly[SqW];
    uv.tex_v = 16'((tv + 20'd1024) >> 11);
  end

  localparam int unsigned Lat = LaneLatency;
  logic [Lat-1:0] vld;
  always_ff @(posedge clk) vld <= {vld[Lat-2:0], go};
  assign done = vld[Lat-1];

endmodule

// File: hw/rtl/scva_merge.sv
// Merge stage: seam fix across the three lanes, position math, vertex
// serializer. Depends on scva_pkg.
module scva_merge import scva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  tri_t        tri_in,
  input  lane_uv_t    uv [3],
  input  logic [15:0] radius,
  input  logic signed [15:0] top [3],
  input  logic signed [15:0] bot [3],
  output logic        valid,
  output vtx_t        vtx
);

  logic signed [15:0] uf [3];
  always_comb begin
    uf[0] = uv[0].tex_u; uf[1] = uv[1].tex_u; uf[2] = uv[2].tex_u;
    if (uf[1] < SeamLo && uf[0] > SeamHi) uf[1] = uf[1] + OneU;
    else if (uf[1] > SeamHi && uf[0] < SeamLo) uf[1] = uf[1] - OneU;
    if (uf[2] < SeamLo && uf[1] > SeamHi && uf[0] > SeamHi) uf[2] = uf[2] + OneU;
    else if (uf[2] > SeamHi && uf[1] < SeamLo && uf[0] < SeamLo) uf[2] = uf[2] - OneU;
  end

  // Hold one triangle; its vertices a, b and c then leave in turn.
  tri_t             t_r;
  logic signed [15:0] u_r [3];
  logic signed [15:0] v_r [3];
  logic [1:0]       cnt;
  logic             act;
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0; cnt <= '0;
    end else if (go) begin
      act <= 1'b1; cnt <= '0;
    end else if (act) begin
      if (cnt == 2'd2) act <= 1'b0;
      cnt <= cnt + 2'd1;
    end
    if (go) begin
      t_r <= tri_in;
      for (int k = 0; k < 3; k++) begin u_r[k] <= uf[k]; v_r[k] <= uv[k].tex_v; end
    end
  end

  logic signed [15:0] p [3];
  logic signed [15:0] tu, tvv;
  logic use_top, eq;
  always_comb begin
    unique case (cnt)
      2'd0: begin p[0]=t_r.a_x; p[1]=t_r.a_y; p[2]=t_r.a_z; tu=u_r[0]; tvv=v_r[0]; end
      2'd1: begin p[0]=t_r.b_x; p[1]=t_r.b_y; p[2]=t_r.b_z; tu=u_r[1]; tvv=v_r[1]; end
      default: begin p[0]=t_r.c_x; p[1]=t_r.c_y; p[2]=t_r.c_z; tu=u_r[2]; tvv=v_r[2]; end
    endcase
    use_top = !t_r.a_z[15] && !t_r.b_z[15] && !t_r.c_z[15];
    eq = p[2] == 16'sd0;
  end

  // Stage 1: products and offset terms.
  logic signed [33:0] prod [3];
  logic signed [33:0] offt [3];
  logic signed [16:0] dv;
  logic signed [15:0] tu1, n1 [3];
  logic signed [15:0] v1;
  logic eq1, last1, val1;
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      logic signed [33:0] o, h;
      o = use_top ? 34'(top[j]) <<< 14 : 34'(bot[j]) <<< 14;
      h = (34'(bot[j]) - 34'(top[j])) <<< 13;
      if (eq) o = use_top ? o + h : o - h;
      prod[j] <= 34'(p[j]) * $signed({18'd0, radius});
      offt[j] <= o;
      n1[j]   <= p[j];
    end
    dv    <= 17'(top[2]) - 17'(bot[2]);
    tu1   <= tu; v1 <= tvv; eq1 <= eq;
    last1 <= cnt == 2'd2;
    val1  <= rst ? 1'b0 : act;
  end

  function automatic logic signed [15:0] sat(input logic signed [34:0] s);
    if (s > 35'sd32767) sat = 16'sh7fff;
    else if (s < -35'sd32768) sat = 16'sh8000;
    else sat = s[15:0];
  endfunction

  always_ff @(posedge clk) begin
    logic signed [34:0] sv;
    sv = 35'(v1) + (eq1 ? 35'(dv) : 35'sd0);
    vtx.pos_x <= sat((35'(prod[0]) + 35'(offt[0]) + 35'sd8192) >>> 14);
    vtx.pos_y <= sat((35'(prod[1]) + 35'(offt[1]) + 35'sd8192) >>> 14);
    vtx.pos_z <= sat((35'(prod[2]) + 35'(offt[2]) + 35'sd8192) >>> 14);
    vtx.nrm_x <= n1[0]; vtx.nrm_y <= n1[1]; vtx.nrm_z <= n1[2];
    vtx.tex_u <= tu1;
    vtx.tex_v <= sat(sv);
    vtx.last  <= last1;
    valid     <= rst ? 1'b0 : val1;
  end

endmodule

// File: hw/rtl/sphere_capsule_vertex_attributes_unit.sv
// Top level of the capsule vertex attribute unit.
// Depends on scva_pkg, scva_lane, scva_merge.
//
// Usage: pulse start with a triangle on tri_in (three unit-sphere corners,
// Q2.14) while busy is low; that transfer is accepted at the clock edge.
// Three lanes, one per corner, compute u (CORDIC on x, y) and v (square
// root, then CORDIC on z) in a fully pipelined way. The merge stage applies
// the seam fix across the three u values and serializes the vertices a, b, c
// onto vtx, each marked by out_valid for one cycle; the third has last set.
// Vertex a comes first; the other two follow on consecutive cycles. Busy is
// raised after each start so that triangles are taken no faster than the single
// vertex port can send their three vertices; the lanes keep working on earlier
// triangles meanwhile.
// The receiver cannot stall, so results leave at a fixed time.
// Configuration: cfg_we, cfg_idx, cfg_data write one of seven registers
// (radius, top offset xyz, bottom offset xyz); other indexes are ignored.
// Reset sets radius to 1.0, offsets to zero, and drops all work in flight.
module sphere_capsule_vertex_attributes_unit import scva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  tri_t        tri_in,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output vtx_t        vtx
);

  logic [15:0] radius;
  logic signed [15:0] top [3];
  logic signed [15:0] bot [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RadiusReset;
      for (int j = 0; j < 3; j++) begin top[j] <= '0; bot[j] <= '0; end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegRadius: radius <= cfg_data;
        RegTopX:   top[0] <= cfg_data;
        RegTopY:   top[1] <= cfg_data;
        RegTopZ:   top[2] <= cfg_data;
        RegBotX:   bot[0] <= cfg_data;
        RegBotY:   bot[1] <= cfg_data;
        RegBotZ:   bot[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The port stays busy after each start while hold counts down, so that vertex
  // transfers of successive triangles never overlap.
  logic [1:0] hold;
  logic       go;
  assign go   = start && !busy;
  assign busy = hold != 2'd0;
  always_ff @(posedge clk) begin
    if (rst) hold <= '0;
    else if (go) hold <= 2'd2;
    else if (hold != 2'd0) hold <= hold - 2'd1;
  end

  // The triangle travels beside the lanes until their results arrive.
  localparam int unsigned LaneLat = LaneLatency;
  tri_t tri_dly [LaneLat+1];
  assign tri_dly[0] = tri_in;
  for (genvar d = 0; d < LaneLat; d++) begin : g_td
    always_ff @(posedge clk) tri_dly[d+1] <= tri_dly[d];
  end

  lane_uv_t uv [3];
  logic [2:0] done;
  scva_lane u_lane_a (.clk, .go, .px(tri_in.a_x), .py(tri_in.a_y), .pz(tri_in.a_z),
                      .uv(uv[0]), .done(done[0]));
  scva_lane u_lane_b (.clk, .go, .px(tri_in.b_x), .py(tri_in.b_y), .pz(tri_in.b_z),
                      .uv(uv[1]), .done(done[1]));
  scva_lane u_lane_c (.clk, .go, .px(tri_in.c_x), .py(tri_in.c_y), .pz(tri_in.c_z),
                      .uv(uv[2]), .done(done[2]));

  // Reset clears these in-flight flags directly; they gate the merge stage's go.
  logic [LaneLat-1:0] live;
  always_ff @(posedge clk) begin
    if (rst) live <= '0;
    else live <= {live[LaneLat-2:0], go};
  end

  scva_merge u_merge (
    .clk, .rst, .go((&done) && live[LaneLat-1]), .tri_in(tri_dly[LaneLat]), .uv,
    .radius, .top, .bot, .valid(out_valid), .vtx
  );

endmodule

// File: hw/rtl/scva_checker.sv
// Port-level checker for the capsule vertex attribute unit, with bind.
// Depends on scva_pkg.
module scva_checker import scva_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic out_valid,
  input vtx_t vtx
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after start");

  a_last_third: assert property (@(posedge clk) disable iff (rst)
    out_valid && vtx.last |-> $past(out_valid, 1) && $past(out_valid, 2))
    else $error("last without two preceding vertices");

  a_no_valid_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("vertex right after reset");

endmodule

bind sphere_capsule_vertex_attributes_unit scva_checker u_scva_checker (
  .clk, .rst, .start, .busy, .out_valid, .vtx
);
